// File: rtl/pst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared types, token kind codes and scan modes for the tokenizer.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int LexemeLimit = 127;
    localparam int OffsetWidth = 24;
    localparam int LineWidth   = 16;
    localparam int FifoDepth   = 4;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_COLON, M_LESS,
        M_GREATER, M_LPAREN, M_BRACE, M_PCOM, M_PSTAR
    } t_mode;

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd12;
    localparam logic [4:0] K_NUMBER  = 5'd13;
    localparam logic [4:0] K_ASSIGN  = 5'd14;
    localparam logic [4:0] K_NE      = 5'd15;
    localparam logic [4:0] K_LE      = 5'd16;
    localparam logic [4:0] K_GE      = 5'd17;
    localparam logic [4:0] K_COLON   = 5'd18;
    localparam logic [4:0] K_LT      = 5'd19;
    localparam logic [4:0] K_GT      = 5'd20;
    localparam logic [4:0] K_SEMI    = 5'd21;
    localparam logic [4:0] K_DOT     = 5'd22;
    localparam logic [4:0] K_COMMA   = 5'd23;
    localparam logic [4:0] K_EQ      = 5'd24;
    localparam logic [4:0] K_PLUS    = 5'd25;
    localparam logic [4:0] K_MINUS   = 5'd26;
    localparam logic [4:0] K_STAR    = 5'd27;
    localparam logic [4:0] K_SLASH   = 5'd28;
    localparam logic [4:0] K_OTHER   = 5'd29;

    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // One token record; offsets and lines are carried at their maximum widths.
    typedef struct packed {
        logic [4:0]  kind;
        logic [1:0]  side;
        logic [31:0] line;
        logic [31:0] start;
        logic [7:0]  length;
        logic [31:0] ival;
        logic [29:0] fval;
        logic [3:0]  fdig;
        logic        sat;
        logic        last;
    } t_token;

    function automatic logic [4:0] keyword_kind(input logic [55:0] w, input logic [7:0] len);
        logic [4:0] k;
        k = K_IDENT;
        case (len)
            8'd2: begin
                if (w[15:0] == "if") k = 5'd7;
                else if (w[15:0] == "do") k = 5'd11;
            end
            8'd3: begin
                if (w[23:0] == "var") k = 5'd2;
                else if (w[23:0] == "end") k = 5'd6;
            end
            8'd4: begin
                if (w[31:0] == "real") k = 5'd4;
                else if (w[31:0] == "then") k = 5'd8;
                else if (w[31:0] == "else") k = 5'd9;
            end
            8'd5: begin
                if (w[39:0] == "begin") k = 5'd5;
                else if (w[39:0] == "while") k = 5'd10;
            end
            8'd7: begin
                if (w == "program") k = 5'd1;
                else if (w == "integer") k = 5'd3;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// File: rtl/pascal_subset_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pascal subset tokenizer
// Turns a stream of source bytes into tokens with position and value.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle whenever the token queue has room for three
// more tokens; the scanner classifies the byte in the same cycle and writes up to
// three tokens into a four-entry queue, which delivers one token per pop.
module pascal_subset_tokenizer #(
    parameter int LEXEME_LIMIT = pst_pkg::LexemeLimit,
    parameter int OFFSET_WIDTH = pst_pkg::OffsetWidth,
    parameter int LINE_WIDTH   = pst_pkg::LineWidth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_char_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [4:0]       o_token_kind,
    output logic [1:0]       o_paren_side,
    output logic [LINE_WIDTH-1:0] o_line_number,
    output logic [OFFSET_WIDTH-1:0] o_start_offset,
    output logic [6:0]       o_lexeme_length,
    output logic [31:0]      o_integer_value,
    output logic [29:0]      o_fraction_value,
    output logic [3:0]       o_fraction_digits,
    output logic             o_value_saturated,
    output logic             o_last_of_run
);
    import pst_pkg::*;

    t_token     tok [3];
    t_token     head;
    logic [1:0] cnt, wcnt;
    logic       take;

    assign take = push && !full;
    assign wcnt = take ? cnt : 2'd0;

    pst_scan #(
        .LEXEME_LIMIT(LEXEME_LIMIT), .OFFSET_WIDTH(OFFSET_WIDTH), .LINE_WIDTH(LINE_WIDTH)
    ) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_char(i_char_byte),
        .o_tok(tok), .o_count(cnt)
    );

    pst_fifo #(.DEPTH(FifoDepth)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_count(wcnt), .i_tok(tok), .i_pop(pop),
        .o_head(head), .o_empty(empty), .o_full(full)
    );

    assign o_token_kind      = head.kind;
    assign o_paren_side      = head.side;
    assign o_line_number     = LINE_WIDTH'(head.line);
    assign o_start_offset    = OFFSET_WIDTH'(head.start);
    assign o_lexeme_length   = head.length[6:0];
    assign o_integer_value   = head.ival;
    assign o_fraction_value  = head.fval;
    assign o_fraction_digits = head.fdig;
    assign o_value_saturated = head.sat;
    assign o_last_of_run     = head.last;

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_token_kind == K_EOF |-> o_last_of_run) else $error("eof not last");
    a_eof_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_token_kind == K_EOF |-> o_lexeme_length == 7'd0) else $error("eof length");
    a_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_token_kind != K_OTHER |-> o_paren_side == SIDE_NONE)
        else $error("paren side");

endmodule
`default_nettype wire

// File: rtl/pst_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Tokenizer scanner
// Front part: takes one byte per transfer and produces up to three tokens.
// ----------------------------------------------------------------------------
module pst_scan #(
    parameter int LEXEME_LIMIT = pst_pkg::LexemeLimit,
    parameter int OFFSET_WIDTH = pst_pkg::OffsetWidth,
    parameter int LINE_WIDTH   = pst_pkg::LineWidth
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_char,
    output pst_pkg::t_token    o_tok [3],
    output logic [1:0]         o_count
);
    import pst_pkg::*;

    localparam int LenW = 8;
    localparam logic [LenW-1:0] Limit = LenW'(LEXEME_LIMIT);
    localparam logic [LINE_WIDTH-1:0] LineMax = '1;

    t_mode                  r_mode, n_mode;
    logic [LINE_WIDTH-1:0]  r_line, n_line, r_tline, n_tline;
    logic [OFFSET_WIDTH-1:0] r_pos, n_pos, r_tstart, n_tstart;
    logic [LenW-1:0]        r_len, n_len;
    logic [55:0]            r_kw, n_kw;
    logic [31:0]            r_iacc, n_iacc;
    logic [29:0]            r_facc, n_facc;
    logic [3:0]             r_fcnt, n_fcnt;
    logic                   r_ovf, n_ovf;

    logic       letter, digit, consumed;
    logic [3:0] dval;
    logic [35:0] imul;
    t_token     tk [3];
    logic [1:0] cnt;
    t_token     cur, word_tok, num_tok;

    assign letter = (i_char >= "a" && i_char <= "z") || (i_char >= "A" && i_char <= "Z")
                    || i_char == "_";
    assign digit  = i_char >= "0" && i_char <= "9";
    assign dval   = 4'(i_char - 8'd48);
    assign imul   = {r_iacc, 3'b000} + {2'b00, r_iacc, 1'b0} + 36'(dval);

    always_comb begin
        cur = '0;
        cur.line   = 32'(r_tline);
        cur.start  = 32'(r_tstart);
        cur.length = r_len;
        word_tok = cur;
        word_tok.kind = keyword_kind(r_kw, r_len);
        num_tok = cur;
        num_tok.kind = K_NUMBER;
        num_tok.ival = r_iacc;
        num_tok.fval = r_facc;
        num_tok.fdig = r_fcnt;
        num_tok.sat  = r_ovf;
    end

    function automatic t_token mk(input logic [4:0] k, input logic [1:0] s,
                                  input logic [31:0] ln, input logic [31:0] st,
                                  input logic [7:0] l);
        t_token t;
        t = '0;
        t.kind = k;
        t.side = s;
        t.line = ln;
        t.start = st;
        t.length = l;
        return t;
    endfunction

    always_comb begin
        n_mode = r_mode; n_line = r_line; n_tline = r_tline; n_pos = r_pos;
        n_tstart = r_tstart; n_len = r_len; n_kw = r_kw; n_iacc = r_iacc;
        n_facc = r_facc; n_fcnt = r_fcnt; n_ovf = r_ovf;
        consumed = 1'b0;
        cnt = 2'd0;
        tk[0] = '0; tk[1] = '0; tk[2] = '0;
        case (r_mode)
            M_IDENT: begin
                if (letter || digit) begin
                    if (r_len < Limit) begin
                        if (r_len < 8'd7) n_kw = {r_kw[47:0], i_char};
                        n_len = r_len + 8'd1;
                    end
                    consumed = 1'b1;
                end else begin
                    tk[0] = word_tok; cnt = 2'd1;
                end
            end
            M_INT: begin
                if (digit) begin
                    if (imul[35:32] != 4'd0) begin
                        n_iacc = '1; n_ovf = 1'b1;
                    end else begin
                        n_iacc = imul[31:0];
                    end
                    if (r_len < Limit) n_len = r_len + 8'd1;
                    consumed = 1'b1;
                end else if (i_char == ".") begin
                    n_mode = M_INT_DOT; consumed = 1'b1;
                end else begin
                    tk[0] = num_tok; cnt = 2'd1;
                end
            end
            M_INT_DOT: begin
                if (digit) begin
                    if (r_len + 8'd2 <= Limit) n_len = r_len + 8'd2;
                    else n_len = Limit;
                    if (r_fcnt < 4'd9) begin
                        n_facc = 30'(r_facc * 30'd10) + 30'(dval);
                        n_fcnt = r_fcnt + 4'd1;
                    end else n_ovf = 1'b1;
                    n_mode = M_FRAC; consumed = 1'b1;
                end else begin
                    tk[0] = num_tok;
                    tk[1] = mk(K_DOT, SIDE_NONE, 32'(r_line), 32'(r_pos - 1'b1), 8'd1);
                    cnt = 2'd2;
                end
            end
            M_FRAC: begin
                if (digit) begin
                    if (r_len < Limit) n_len = r_len + 8'd1;
                    if (r_fcnt < 4'd9) begin
                        n_facc = 30'(r_facc * 30'd10) + 30'(dval);
                        n_fcnt = r_fcnt + 4'd1;
                    end else n_ovf = 1'b1;
                    consumed = 1'b1;
                end else begin
                    tk[0] = num_tok; cnt = 2'd1;
                end
            end
            M_COLON: begin
                consumed = i_char == "=";
                tk[0] = mk(consumed ? K_ASSIGN : K_COLON, SIDE_NONE, cur.line, cur.start,
                           consumed ? 8'd2 : 8'd1);
                cnt = 2'd1;
            end
            M_LESS: begin
                consumed = i_char == ">" || i_char == "=";
                tk[0] = mk(i_char == ">" ? K_NE : (i_char == "=" ? K_LE : K_LT), SIDE_NONE,
                           cur.line, cur.start, consumed ? 8'd2 : 8'd1);
                cnt = 2'd1;
            end
            M_GREATER: begin
                consumed = i_char == "=";
                tk[0] = mk(consumed ? K_GE : K_GT, SIDE_NONE, cur.line, cur.start,
                           consumed ? 8'd2 : 8'd1);
                cnt = 2'd1;
            end
            M_LPAREN: begin
                if (i_char == "*") begin
                    n_mode = M_PCOM; consumed = 1'b1;
                end else begin
                    tk[0] = mk(K_OTHER, SIDE_LEFT, cur.line, cur.start, 8'd1);
                    cnt = 2'd1;
                end
            end
            M_BRACE: begin
                if (i_char != 8'd0) begin
                    consumed = 1'b1;
                    if (i_char == "}") n_mode = M_IDLE;
                    else if (i_char == 8'd10 && r_line != LineMax) n_line = r_line + 1'b1;
                end
            end
            M_PCOM, M_PSTAR: begin
                if (i_char != 8'd0) begin
                    consumed = 1'b1;
                    if (r_mode == M_PSTAR && i_char == ")") n_mode = M_IDLE;
                    else if (i_char == "*") n_mode = M_PSTAR;
                    else begin
                        if (i_char == 8'd10 && r_line != LineMax) n_line = r_line + 1'b1;
                        n_mode = M_PCOM;
                    end
                end
            end
            default: consumed = 1'b0;
        endcase

        if (!consumed) begin
            n_mode = M_IDLE;
            if (i_char == 8'd0) begin
                tk[cnt] = mk(K_EOF, SIDE_NONE, 32'(r_line), 32'(r_pos), 8'd0);
                cnt = cnt + 2'd1;
                n_line = LINE_WIDTH'(1); n_tline = LINE_WIDTH'(1); n_tstart = '0;
                n_len = '0; n_kw = '0; n_iacc = '0; n_facc = '0; n_fcnt = '0; n_ovf = 1'b0;
            end else if (i_char == " " || i_char == 8'd9 || i_char == 8'd13) begin
                n_mode = M_IDLE;
            end else if (i_char == 8'd10) begin
                if (r_line != LineMax) n_line = r_line + 1'b1;
            end else if (i_char == "{") begin
                n_mode = M_BRACE;
            end else if (letter || digit || i_char == ":" || i_char == "<" ||
                         i_char == ">" || i_char == "(") begin
                n_tstart = r_pos; n_tline = r_line; n_len = 8'd1;
                n_kw = '0; n_iacc = '0; n_facc = '0; n_fcnt = '0; n_ovf = 1'b0;
                if (letter) begin
                    n_mode = M_IDENT; n_kw = 56'(i_char);
                end else if (digit) begin
                    n_mode = M_INT; n_iacc = 32'(dval);
                end else if (i_char == ":") n_mode = M_COLON;
                else if (i_char == "<") n_mode = M_LESS;
                else if (i_char == ">") n_mode = M_GREATER;
                else n_mode = M_LPAREN;
            end else begin
                tk[cnt] = mk(K_OTHER, SIDE_NONE, 32'(r_line), 32'(r_pos), 8'd1);
                case (i_char)
                    ";": tk[cnt].kind = K_SEMI;
                    ".": tk[cnt].kind = K_DOT;
                    ",": tk[cnt].kind = K_COMMA;
                    "=": tk[cnt].kind = K_EQ;
                    "+": tk[cnt].kind = K_PLUS;
                    "-": tk[cnt].kind = K_MINUS;
                    "*": tk[cnt].kind = K_STAR;
                    "/": tk[cnt].kind = K_SLASH;
                    ")": tk[cnt].side = SIDE_RIGHT;
                    default: tk[cnt].kind = K_OTHER;
                endcase
                cnt = cnt + 2'd1;
            end
        end
        n_pos = (i_char == 8'd0 && !consumed) ? '0 : r_pos + 1'b1;
        if (cnt != 2'd0) tk[cnt - 2'd1].last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_line <= LINE_WIDTH'(1); r_tline <= LINE_WIDTH'(1);
            r_pos <= '0; r_tstart <= '0; r_len <= '0; r_kw <= '0; r_iacc <= '0;
            r_facc <= '0; r_fcnt <= '0; r_ovf <= 1'b0;
        end else if (i_take) begin
            r_mode <= n_mode; r_line <= n_line; r_tline <= n_tline; r_pos <= n_pos;
            r_tstart <= n_tstart; r_len <= n_len; r_kw <= n_kw; r_iacc <= n_iacc;
            r_facc <= n_facc; r_fcnt <= n_fcnt; r_ovf <= n_ovf;
        end
    end

    assign o_tok   = tk;
    assign o_count = cnt;

endmodule
`default_nettype wire

// File: rtl/pst_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Token queue
// Accepts up to three tokens in one cycle and releases one per transfer.
// ----------------------------------------------------------------------------
module pst_fifo #(
    parameter int DEPTH = pst_pkg::FifoDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [1:0]  i_count,
    input  wire pst_pkg::t_token i_tok [3],
    input  wire logic        i_pop,
    output pst_pkg::t_token  o_head,
    output logic             o_empty,
    output logic             o_full
);
    import pst_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_token          r_mem [DEPTH];
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_used, n_used;
    logic [AW-1:0]   wa [3];

    assign o_empty = r_used == '0;
    // Room must exist for the largest burst of one byte.
    assign o_full  = r_used > (AW+1)'(DEPTH - 3);
    assign o_head  = r_mem[r_rd];
    assign n_used  = r_used + (AW+1)'(i_count) - (AW+1)'(i_pop && !o_empty);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wa[k] = AW'(r_rd + AW'(r_used) + AW'(k));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_count) r_mem[wa[k]] <= i_tok[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_used <= '0;
        end else begin
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
            r_used <= n_used;
        end
    end

endmodule
`default_nettype wire

// File: tb/pascal_subset_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// Pascal subset tokenizer testbench
// Sends source bytes through the push side and checks every token popped
// against a scanner model kept in the testbench, field by field.
// ----------------------------------------------------------------------------
module pascal_subset_tokenizer_tb;
    import pst_pkg::*;

    typedef struct {
        logic [4:0]  kind;
        logic [1:0]  side;
        logic [15:0] line;
        logic [23:0] start;
        logic [6:0]  length;
        logic [31:0] ival;
        logic [29:0] fval;
        logic [3:0]  fdig;
        logic        sat;
        logic        last;
    } t_expect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic [7:0]  i_char_byte = 8'd0;
    logic        pop = 1'b0;
    logic        full;
    logic        empty;
    logic [4:0]  o_token_kind;
    logic [1:0]  o_paren_side;
    logic [15:0] o_line_number;
    logic [23:0] o_start_offset;
    logic [6:0]  o_lexeme_length;
    logic [31:0] o_integer_value;
    logic [29:0] o_fraction_value;
    logic [3:0]  o_fraction_digits;
    logic        o_value_saturated;
    logic        o_last_of_run;

    t_expect     token_queue[$];
    int          error_count = 0;
    bit          sender_gaps = 1'b1;
    bit          receiver_gaps = 1'b1;
    int          hold_cycles = 0;
    int          long_hold_requests = 0;
    int          long_hold_grants = 0;

    t_mode       mode;
    logic [15:0] line_cnt;
    logic [23:0] char_pos;
    logic [23:0] tok_start;
    logic [15:0] tok_line;
    logic [6:0]  tok_len;
    logic [55:0] kw_window;
    logic [31:0] int_acc;
    logic [29:0] frac_acc;
    logic [3:0]  frac_cnt;
    logic        ovf;

    pascal_subset_tokenizer u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_char_byte(i_char_byte), .empty(empty), .pop(pop),
        .o_token_kind(o_token_kind), .o_paren_side(o_paren_side),
        .o_line_number(o_line_number), .o_start_offset(o_start_offset),
        .o_lexeme_length(o_lexeme_length), .o_integer_value(o_integer_value),
        .o_fraction_value(o_fraction_value), .o_fraction_digits(o_fraction_digits),
        .o_value_saturated(o_value_saturated), .o_last_of_run(o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic clear_scanner();
        mode = M_IDLE;
        line_cnt = 16'd1;
        char_pos = '0;
        tok_start = '0;
        tok_line = 16'd1;
        tok_len = '0;
        kw_window = '0;
        int_acc = '0;
        frac_acc = '0;
        frac_cnt = '0;
        ovf = 1'b0;
    endtask

    task automatic add_token(inout t_expect run[$], input logic [4:0] kind,
                             input logic [1:0] side, input logic [15:0] line,
                             input logic [23:0] start, input logic [6:0] len,
                             input logic [31:0] iv, input logic [29:0] fv,
                             input logic [3:0] fd, input logic sat);
        t_expect t;
        t.kind = kind; t.side = side; t.line = line; t.start = start;
        t.length = len; t.ival = iv; t.fval = fv; t.fdig = fd; t.sat = sat;
        t.last = 1'b0;
        run.push_back(t);
    endtask

    function automatic logic [4:0] word_kind();
        logic [4:0] k;
        k = K_IDENT;
        case (tok_len)
            7'd2: if (kw_window[15:0] == "if") k = 5'd7;
                  else if (kw_window[15:0] == "do") k = 5'd11;
            7'd3: if (kw_window[23:0] == "var") k = 5'd2;
                  else if (kw_window[23:0] == "end") k = 5'd6;
            7'd4: if (kw_window[31:0] == "real") k = 5'd4;
                  else if (kw_window[31:0] == "then") k = 5'd8;
                  else if (kw_window[31:0] == "else") k = 5'd9;
            7'd5: if (kw_window[39:0] == "begin") k = 5'd5;
                  else if (kw_window[39:0] == "while") k = 5'd10;
            7'd7: if (kw_window == "program") k = 5'd1;
                  else if (kw_window == "integer") k = 5'd3;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    task automatic grow_len();
        if (tok_len < 7'd127) tok_len++;
    endtask

    task automatic bump_line();
        if (line_cnt != 16'hFFFF) line_cnt++;
    endtask

    task automatic open_token(t_mode m, logic [23:0] pos);
        mode = m; tok_start = pos; tok_line = line_cnt; tok_len = 7'd1;
        kw_window = '0; int_acc = '0; frac_acc = '0; frac_cnt = '0; ovf = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] c);
        t_expect     run[$];
        logic [23:0] pos;
        logic [15:0] line;
        logic [35:0] wide;
        logic [4:0]  kind;
        logic [1:0]  side;
        bit          used;
        bit          eof;
        pos = char_pos;
        line = line_cnt;
        used = 1'b0;
        eof = 1'b0;
        case (mode)
            M_IDENT: begin
                if (is_alpha(c) || is_num(c)) begin
                    if (tok_len < 7'd127) begin
                        if (tok_len < 7'd7) kw_window = {kw_window[47:0], c};
                        tok_len++;
                    end
                    used = 1'b1;
                end else begin
                    add_token(run, word_kind(), SIDE_NONE, tok_line, tok_start,
                              tok_len, 0, 0, 0, 0);
                end
            end
            M_INT: begin
                if (is_num(c)) begin
                    wide = int_acc * 36'd10 + (c - "0");
                    if (wide > 36'hFFFF_FFFF) begin
                        wide = 36'hFFFF_FFFF;
                        ovf = 1'b1;
                    end
                    int_acc = wide[31:0];
                    grow_len();
                    used = 1'b1;
                end else if (c == ".") begin
                    mode = M_INT_DOT;
                    used = 1'b1;
                end else begin
                    add_token(run, K_NUMBER, SIDE_NONE, tok_line, tok_start, tok_len,
                              int_acc, frac_acc, frac_cnt, ovf);
                end
            end
            M_INT_DOT, M_FRAC: begin
                if (is_num(c)) begin
                    if (mode == M_INT_DOT) grow_len();
                    grow_len();
                    if (frac_cnt < 4'd9) begin
                        frac_acc = frac_acc * 30'd10 + (c - "0");
                        frac_cnt++;
                    end else begin
                        ovf = 1'b1;
                    end
                    mode = M_FRAC;
                    used = 1'b1;
                end else begin
                    add_token(run, K_NUMBER, SIDE_NONE, tok_line, tok_start, tok_len,
                              int_acc, frac_acc, frac_cnt, ovf);
                    if (mode == M_INT_DOT)
                        add_token(run, K_DOT, SIDE_NONE, line, pos - 24'd1, 1, 0, 0, 0, 0);
                end
            end
            M_COLON: begin
                used = (c == "=");
                add_token(run, used ? K_ASSIGN : K_COLON, SIDE_NONE, tok_line, tok_start,
                          used ? 7'd2 : 7'd1, 0, 0, 0, 0);
            end
            M_LESS: begin
                used = (c == ">" || c == "=");
                kind = (c == ">") ? K_NE : (c == "=") ? K_LE : K_LT;
                add_token(run, kind, SIDE_NONE, tok_line, tok_start,
                          used ? 7'd2 : 7'd1, 0, 0, 0, 0);
            end
            M_GREATER: begin
                used = (c == "=");
                add_token(run, used ? K_GE : K_GT, SIDE_NONE, tok_line, tok_start,
                          used ? 7'd2 : 7'd1, 0, 0, 0, 0);
            end
            M_LPAREN: begin
                if (c == "*") begin
                    mode = M_PCOM;
                    used = 1'b1;
                end else begin
                    add_token(run, K_OTHER, SIDE_LEFT, tok_line, tok_start, 1, 0, 0, 0, 0);
                end
            end
            M_BRACE: begin
                if (c != 8'd0) begin
                    if (c == "}") mode = M_IDLE;
                    else if (c == 8'h0A) bump_line();
                    used = 1'b1;
                end
            end
            M_PCOM, M_PSTAR: begin
                if (c != 8'd0) begin
                    if (mode == M_PSTAR && c == ")") mode = M_IDLE;
                    else if (c == "*") mode = M_PSTAR;
                    else begin
                        if (c == 8'h0A) bump_line();
                        mode = M_PCOM;
                    end
                    used = 1'b1;
                end
            end
            default: ;
        endcase
        if (!used) begin
            mode = M_IDLE;
            line = line_cnt;
            if (c == 8'd0) begin
                add_token(run, K_EOF, SIDE_NONE, line, pos, 0, 0, 0, 0, 0);
                clear_scanner();
                eof = 1'b1;
            end else if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
                if (c == 8'h0A) bump_line();
            end else if (c == "{") begin
                mode = M_BRACE;
            end else if (is_alpha(c)) begin
                open_token(M_IDENT, pos);
                kw_window = {48'd0, c};
            end else if (is_num(c)) begin
                open_token(M_INT, pos);
                int_acc = c - "0";
            end else if (c == ":") begin
                open_token(M_COLON, pos);
            end else if (c == "<") begin
                open_token(M_LESS, pos);
            end else if (c == ">") begin
                open_token(M_GREATER, pos);
            end else if (c == "(") begin
                open_token(M_LPAREN, pos);
            end else begin
                side = SIDE_NONE;
                case (c)
                    ";": kind = K_SEMI;
                    ".": kind = K_DOT;
                    ",": kind = K_COMMA;
                    "=": kind = K_EQ;
                    "+": kind = K_PLUS;
                    "-": kind = K_MINUS;
                    "*": kind = K_STAR;
                    "/": kind = K_SLASH;
                    ")": begin kind = K_OTHER; side = SIDE_RIGHT; end
                    default: kind = K_OTHER;
                endcase
                add_token(run, kind, side, line, pos, 1, 0, 0, 0, 0);
            end
        end
        if (!eof) char_pos = pos + 24'd1;
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) token_queue.push_back(run[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_byte(input logic [7:0] c);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_char_byte <= c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        scan_byte(c);
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (token_queue.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            pop <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (long_hold_grants < long_hold_requests) begin
            pop <= 1'b0;
            hold_cycles <= 60;
            long_hold_grants <= long_hold_grants + 1;
        end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            hold_cycles <= $urandom_range(0, 4);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && pop && !empty) begin
            if (token_queue.size() == 0) begin
                $display("unexpected token kind %0d at %0t", o_token_kind, $realtime);
                error_count++;
            end else begin
                e = token_queue.pop_front();
                if (o_token_kind !== e.kind) report_mismatch("kind", o_token_kind, e.kind);
                if (o_paren_side !== e.side) report_mismatch("side", o_paren_side, e.side);
                if (o_line_number !== e.line) report_mismatch("line", o_line_number, e.line);
                if (o_start_offset !== e.start)
                    report_mismatch("offset", o_start_offset, e.start);
                if (o_lexeme_length !== e.length)
                    report_mismatch("length", o_lexeme_length, e.length);
                if (o_integer_value !== e.ival)
                    report_mismatch("integer", o_integer_value, e.ival);
                if (o_fraction_value !== e.fval)
                    report_mismatch("fraction", o_fraction_value, e.fval);
                if (o_fraction_digits !== e.fdig)
                    report_mismatch("digits", o_fraction_digits, e.fdig);
                if (o_value_saturated !== e.sat)
                    report_mismatch("saturated", o_value_saturated, e.sat);
                if (o_last_of_run !== e.last) report_mismatch("last", o_last_of_run, e.last);
            end
        end
    end

    function automatic logic [7:0] random_source_byte();
        string pool;
        pool = "abeginwhilethendo_Z09:=<>;.,+-*/(){}\n \t\r";
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1, 2: return 8'("0" + $urandom_range(0, 9));
            default: return pool[$urandom_range(0, pool.len() - 1)];
        endcase
    endfunction

    task automatic test_keywords_and_symbols();
        send_text("program var integer real begin end if then else while do x_1 Ab\n");
        send_text(":= <> <= >= : < > ; . , = + - * / ( ) ?");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'd0);
    endtask

    task automatic test_numbers();
        send_text("12.5 7.x 4294967295 4294967296 99999999999 ");
        send_text("1.1234567891234 0. 3.14159 ");
        send_byte(8'd0);
    endtask

    task automatic test_comments();
        send_text("a{ x\n y }b(* z\n (*) * *)c (x) (");
        send_byte(8'd0);
        send_text("{ open");
        send_byte(8'd0);
        send_text("(* open *");
        send_byte(8'd0);
        send_text("12.");
        send_byte(8'd0);
    endtask

    task automatic test_long_identifier();
        send_text("integer");
        for (int i = 0; i < 130; i++) send_byte("q");
        send_text(" program");
        for (int i = 0; i < 12; i++) send_byte("7");
        send_byte(8'd0);
    endtask

    task automatic test_random_sources();
        int    count;
        string phrase;
        count = 0;
        phrase = "while x1 <= 42.75 do begin y := y + 3; end;\n";
        while (count < 100) begin
            if ($urandom_range(0, 3) == 0) begin
                send_text(phrase);
                count += phrase.len();
            end else begin
                send_byte(random_source_byte());
                count++;
            end
            if ($urandom_range(0, 60) == 0) send_byte(8'd0);
            if (count > 70) begin
                sender_gaps = 1'b0;
                receiver_gaps = 1'b0;
            end
        end
        send_byte(8'd0);
    endtask

    task automatic test_back_pressure();
        long_hold_requests++;
        send_text("a;b;c;d;e;f;g;h;(");
        send_byte(8'd0);
        wait_drained();
    endtask

    initial begin
        clear_scanner();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_keywords_and_symbols();
        test_numbers();
        test_comments();
        wait_drained();
        test_long_identifier();
        test_back_pressure();
        test_random_sources();
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (error_count == 0 && token_queue.size() == 0) begin
            $display("pascal_subset_tokenizer test passed");
        end else begin
            $display("pascal_subset_tokenizer test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("pascal_subset_tokenizer test failed");
        $finish;
    end
endmodule
